// ===== src/rms_current_meter_macros.svh =====
// assertion macros shared by the rms current meter rtl
`ifndef RMS_CURRENT_METER_MACROS_SVH
`define RMS_CURRENT_METER_MACROS_SVH

// same-cycle implication, checked outside reset
`define RCM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rms current meter check failed");

// next-cycle implication, checked outside reset
`define RCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rms current meter check failed");

`endif

// ===== src/rcm_pkg.sv =====
// constants shared by the rms current meter modules
package rcm_pkg;

    localparam int ADC_WIDTH_DEFAULT = 12;
    localparam int FRAC_W            = 16;
    localparam int CAL_W             = 24;
    localparam int WIN_W             = 12;
    localparam int SAMPLE_W          = 12;
    localparam int IN_DATA_W         = 16;
    localparam int RESULT_W          = 32;
    localparam int CFG_ADDR_W        = 1;
    localparam int CFG_DATA_W        = 24;
    localparam int MUL_W             = 32;

    localparam logic [WIN_W-1:0] WIN_RESET = 12'd1480;

    // register indexes on the write port
    localparam logic [CFG_ADDR_W-1:0] REG_CALIBRATION  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_COUNT = 1'b1;

    // 3.3 is applied as 33 / 10: times 33 by shift and add, then a divide by ten
    // as a multiply by ceil(2^33 / 10), exact for a dividend below 2^30
    localparam int               SCALE_SHIFT     = 5;
    localparam logic [MUL_W-1:0] SCALE_RCP       = 32'd858993460;
    localparam int               SCALE_RCP_SHIFT = 33;

endpackage

// ===== src/rcm_sub.sv =====
// shared subtract and compare unit for the divide and square-root steps
module rcm_sub #(
    parameter int WIDTH = 31
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] diff,
    output logic             ge
);

    logic [WIDTH:0] full;

    assign full = {1'b0, a} - {1'b0, b};
    assign diff = full[WIDTH-1:0];
    assign ge   = ~full[WIDTH];

endmodule

// ===== src/rcm_mul.sv =====
// shared multiplier with a registered product
module rcm_mul #(
    parameter int WIDTH = 28
) (
    input  logic               clk,
    input  logic [WIDTH-1:0]   a,
    input  logic [WIDTH-1:0]   b,
    output logic [2*WIDTH-1:0] prod
);

    logic [2*WIDTH-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== src/rms_current_meter.sv =====
// rms current meter: dc offset tracking, square sum, divide, root and scaling
// each sample passes through accept, offset update, magnitude, square and accumulate
// a closing sample adds 2*ADC_WIDTH+28 restoring divide steps for the mean, ADC_WIDTH+16 root
// steps, the calibration multiply, the times-33 scaling, the divide by ten and the output
// state, which waits out any output stall; no new sample is taken before then; one shared
// subtract unit and one shared multiplier; reset: offset mid-scale, window 1480, no result
module rms_current_meter #(
    parameter int ADC_WIDTH = rcm_pkg::ADC_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // sample [11:0], zero padding above
    input  logic [rcm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // rms_current [31:0]
    output logic [rcm_pkg::RESULT_W-1:0]     m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             cfg_we,
    input  logic [rcm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [rcm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    `include "rms_current_meter_macros.svh"

    localparam int FRAC_W = rcm_pkg::FRAC_W;
    localparam int WIN_W  = rcm_pkg::WIN_W;
    localparam int CAL_W  = rcm_pkg::CAL_W;
    localparam int RES_W  = rcm_pkg::RESULT_W;
    localparam int MUL_W  = rcm_pkg::MUL_W;
    localparam int OFS_W  = ADC_WIDTH + FRAC_W;
    localparam int DIFF_W = OFS_W + 1;
    localparam int MEAN_W = 2 * ADC_WIDTH + FRAC_W;
    localparam int SUM_W  = MEAN_W + WIN_W;
    localparam int SQ_W   = MEAN_W + FRAC_W;
    localparam int ALU_W  = ADC_WIDTH + 19;
    localparam int IT_W   = $clog2(SUM_W);
    localparam int P_W    = CAL_W + FRAC_W;
    localparam int QS_W   = P_W + rcm_pkg::SCALE_SHIFT + 1;

    localparam logic [OFS_W-1:0] OFS_RESET = OFS_W'(1) << (OFS_W - 1);
    localparam logic [OFS_W-1:0] OFS_MAX   = {{ADC_WIDTH{1'b1}}, {FRAC_W{1'b0}}};

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_OFS  = 4'd1;
    localparam logic [3:0] S_MAG  = 4'd2;
    localparam logic [3:0] S_SQR  = 4'd3;
    localparam logic [3:0] S_ACC  = 4'd4;
    localparam logic [3:0] S_DIVM = 4'd5;
    localparam logic [3:0] S_SQRT = 4'd6;
    localparam logic [3:0] S_CAL  = 4'd7;
    localparam logic [3:0] S_SCL  = 4'd8;
    localparam logic [3:0] S_DIVS = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0]           state_reg, state_next;
    logic [ADC_WIDTH-1:0] raw_reg, raw_next;
    logic [OFS_W-1:0]     ofs_reg, ofs_next;
    logic [OFS_W-1:0]     mag_reg, mag_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [WIN_W-1:0]     count_reg, count_next;
    logic [SUM_W-1:0]     dq_reg, dq_next;
    logic [WIN_W-1:0]     div_reg, div_next;
    logic [ALU_W-1:0]     rem_reg, rem_next;
    logic [OFS_W-1:0]     root_reg, root_next;
    logic [SQ_W-1:0]      xs_reg, xs_next;
    logic [IT_W-1:0]      it_reg, it_next;
    logic [RES_W-1:0]     out_data_reg, out_data_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CAL_W-1:0]     cal_reg;
    logic [WIN_W-1:0]     win_reg;

    logic [OFS_W-1:0]        raw16;
    logic signed [DIFF_W-1:0] diff_ofs;
    logic signed [DIFF_W-1:0] step_ofs;
    logic [DIFF_W-1:0]       neg_diff;
    logic [OFS_W-1:0]        mag_val;
    logic [SUM_W-1:0]        sum_add;
    logic [WIN_W:0]          count_inc;
    logic [WIN_W-1:0]        limit;
    logic [SUM_W-1:0]        quot_step;
    logic [P_W-1:0]          p_val;
    logic [QS_W-1:0]         qs_val;
    logic                    out_free;

    logic [ALU_W-1:0]     alu_a, alu_b, alu_diff;
    logic                 alu_ge;
    logic [MUL_W-1:0]     mul_a, mul_b;
    logic [2*MUL_W-1:0]   mul_prod;
    logic [ALU_W-1:0]     rem_bound;
    logic [ALU_W-1:0]     div_ext;

    rcm_sub #(
        .WIDTH (ALU_W)
    ) u_sub (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .ge   (alu_ge)
    );

    rcm_mul #(
        .WIDTH (MUL_W)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    // offset and magnitude path
    assign raw16    = {raw_reg, {FRAC_W{1'b0}}};
    assign diff_ofs = $signed({1'b0, raw16}) - $signed({1'b0, ofs_reg});
    assign step_ofs = diff_ofs >>> ADC_WIDTH;
    assign neg_diff = -diff_ofs;
    assign mag_val  = diff_ofs[DIFF_W-1] ? neg_diff[OFS_W-1:0] : diff_ofs[OFS_W-1:0];

    assign sum_add   = sum_reg + SUM_W'(mul_prod >> FRAC_W);
    assign count_inc = {1'b0, count_reg} + (WIN_W+1)'(1);
    assign limit     = (win_reg == '0) ? WIN_W'(1) : win_reg;
    assign quot_step = {dq_reg[SUM_W-2:0], alu_ge};

    // final scale: p = cal * r >> adc width, then p * 33 >> 16, divided by ten later
    assign p_val  = P_W'(mul_prod >> ADC_WIDTH);
    assign qs_val = (QS_W'(p_val) << rcm_pkg::SCALE_SHIFT) + QS_W'(p_val);

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign rem_bound = ALU_W'({root_reg, 1'b0});
    assign div_ext   = ALU_W'(div_reg);

    // operand selection for the shared units
    always_comb
    begin
        alu_a = '0;
        alu_b = '0;
        mul_a = MUL_W'(mag_reg);
        mul_b = MUL_W'(mag_reg);
        unique case (state_reg)
            S_DIVM:
            begin
                alu_a = ALU_W'({rem_reg[WIN_W-1:0], dq_reg[SUM_W-1]});
                alu_b = div_ext;
            end
            S_SQRT:
            begin
                alu_a = {rem_reg[ALU_W-3:0], xs_reg[SQ_W-1 -: 2]};
                alu_b = ALU_W'({root_reg, 2'b01});
            end
            S_CAL:
            begin
                mul_a = MUL_W'(cal_reg);
                mul_b = MUL_W'(root_reg);
            end
            // divide by ten as a reciprocal multiply, held while the output waits
            S_DIVS, S_OUT:
            begin
                mul_a = MUL_W'(dq_reg[QS_W-FRAC_W-1:0]);
                mul_b = rcm_pkg::SCALE_RCP;
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        raw_next       = raw_reg;
        ofs_next       = ofs_reg;
        mag_next       = mag_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        dq_next        = dq_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        xs_next        = xs_reg;
        it_next        = it_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    raw_next   = ADC_WIDTH'(s_axis_tdata[rcm_pkg::SAMPLE_W-1:0]);
                    state_next = S_OFS;
                end
            end
            S_OFS:
            begin
                ofs_next   = ofs_reg + step_ofs[OFS_W-1:0];
                state_next = S_MAG;
            end
            S_MAG:
            begin
                mag_next   = mag_val;
                state_next = S_SQR;
            end
            S_SQR:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (count_inc >= {1'b0, limit})
                begin
                    dq_next    = sum_add;
                    div_next   = count_inc[WIN_W-1:0];
                    rem_next   = '0;
                    it_next    = '0;
                    sum_next   = '0;
                    count_next = '0;
                    state_next = S_DIVM;
                end
                else
                begin
                    sum_next   = sum_add;
                    count_next = count_inc[WIN_W-1:0];
                    state_next = S_IDLE;
                end
            end
            S_DIVM:
            begin
                dq_next  = quot_step;
                rem_next = alu_ge ? alu_diff
                                  : ALU_W'({rem_reg[WIN_W-1:0], dq_reg[SUM_W-1]});
                it_next  = it_reg + IT_W'(1);
                if (it_reg == IT_W'(SUM_W - 1))
                begin
                    xs_next    = {quot_step[MEAN_W-1:0], {FRAC_W{1'b0}}};
                    rem_next   = '0;
                    root_next  = '0;
                    it_next    = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                rem_next  = alu_ge ? alu_diff : alu_a;
                root_next = {root_reg[OFS_W-2:0], alu_ge};
                xs_next   = xs_reg << 2;
                it_next   = it_reg + IT_W'(1);
                if (it_reg == IT_W'(OFS_W - 1))
                begin
                    state_next = S_CAL;
                end
            end
            S_CAL:
            begin
                state_next = S_SCL;
            end
            S_SCL:
            begin
                dq_next    = SUM_W'(qs_val[QS_W-1:FRAC_W]);
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    // quotient stays below 2^31, so no saturation is needed
                    out_data_next  = RES_W'(mul_prod >> rcm_pkg::SCALE_RCP_SHIFT);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ofs_reg       <= OFS_RESET;
            sum_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            cal_reg       <= '0;
            win_reg       <= rcm_pkg::WIN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            ofs_reg       <= ofs_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    rcm_pkg::REG_CALIBRATION:  cal_reg <= cfg_data[CAL_W-1:0];
                    rcm_pkg::REG_SAMPLE_COUNT: win_reg <= cfg_data[WIN_W-1:0];
                    default:                   cal_reg <= cal_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg      <= raw_next;
        mag_reg      <= mag_next;
        dq_reg       <= dq_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        xs_reg       <= xs_next;
        it_reg       <= it_next;
        out_data_reg <= out_data_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tvalid = out_valid_reg;

    `RCM_ASSERT_IMP(a_ofs_range, 1'b1, ofs_reg <= OFS_MAX)
    `RCM_ASSERT_IMP(a_div_rem, state_reg == S_DIVM, rem_reg < div_ext)
    `RCM_ASSERT_IMP(a_root_rem, state_reg == S_SQRT, rem_reg <= rem_bound)
    `RCM_ASSERT_NEXT(a_out_load, !out_valid_reg && (state_reg != S_OUT), !m_axis_tvalid)

endmodule

// ===== test/tb_rms_current_meter.sv =====
// testbench for rms_current_meter: random and directed samples checked against a window predictor
module tb_rms_current_meter;

    localparam int ADC_W         = rcm_pkg::ADC_WIDTH_DEFAULT;
    localparam int FRAC_W        = rcm_pkg::FRAC_W;
    localparam int CAL_W         = rcm_pkg::CAL_W;
    localparam int WIN_W         = rcm_pkg::WIN_W;
    localparam int SMP_W         = rcm_pkg::SAMPLE_W;
    localparam int RES_W         = rcm_pkg::RESULT_W;
    localparam int IDX_W         = rcm_pkg::CFG_ADDR_W;
    localparam int CFG_W         = rcm_pkg::CFG_DATA_W;
    localparam int RANDOM_ITEMS  = 900;
    localparam int LONG_WINDOW   = 1000;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 400;
    localparam int CYCLE_LIMIT   = 4000000;
    localparam logic [CAL_W-1:0] CAL_MAX = {CAL_W{1'b1}};

    // predicts the rms value of every closed window and checks the block output
    class rms_window_tracker;
        logic [CAL_W-1:0]     calibration;
        logic [WIN_W-1:0]     window_len;
        longint               dc_offset;
        longint unsigned      square_sum;
        int unsigned          window_fill;
        logic [RES_W-1:0]     expected_rms[$];
        int unsigned          errors;

        function new();
            calibration = '0;
            window_len  = rcm_pkg::WIN_RESET;
            dc_offset   = longint'(1) <<< (ADC_W - 1 + FRAC_W);
            square_sum  = 0;
            window_fill = 0;
            errors      = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                rcm_pkg::REG_CALIBRATION:  calibration = value[CAL_W-1:0];
                rcm_pkg::REG_SAMPLE_COUNT: window_len  = value[WIN_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned root, rem_v, trial;
            root  = 0;
            rem_v = 0;
            for (int i = 31; i >= 0; i--) begin
                rem_v = (rem_v << 2) | ((x >> (2 * i)) & 64'd3);
                trial = (root << 2) | 64'd1;
                root  = root << 1;
                if (rem_v >= trial) begin
                    rem_v = rem_v - trial;
                    root  = root | 64'd1;
                end
            end
            return root;
        endfunction

        function void note_sample(logic [SMP_W-1:0] raw);
            longint          raw16, diff, filt;
            longint unsigned mag, lim, mean, root, scaled, amps;
            raw16 = longint'(raw) <<< FRAC_W;
            diff  = raw16 - dc_offset;
            // arithmetic shift gives the floor, also for negative distances
            dc_offset = dc_offset + (diff >>> ADC_W);
            filt = raw16 - dc_offset;
            mag  = (filt < 0) ? -filt : filt;
            square_sum  = square_sum + ((mag * mag) >> FRAC_W);
            window_fill = window_fill + 1;
            lim = (window_len == 0) ? 1 : window_len;
            if (window_fill >= lim) begin
                mean   = square_sum / window_fill;
                root   = int_sqrt(mean << FRAC_W);
                scaled = (calibration * root) >> ADC_W;
                amps   = (scaled * 33) / 655360;
                if (amps > 64'hFFFF_FFFF)
                    amps = 64'hFFFF_FFFF;
                expected_rms.push_back(amps[RES_W-1:0]);
                square_sum  = 0;
                window_fill = 0;
            end
        endfunction

        function void check_result(logic [RES_W-1:0] got);
            logic [RES_W-1:0] want;
            if (expected_rms.size() == 0) begin
                $error("rms_current: unexpected result, got %0d", got);
                errors++;
                return;
            end
            want = expected_rms.pop_front();
            if (got !== want) begin
                $error("rms_current mismatch: expected %0d, got %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic [rcm_pkg::IN_DATA_W-1:0]    s_axis_tdata;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [RES_W-1:0]                 m_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic                             cfg_we;
    logic [IDX_W-1:0]                 cfg_addr;
    logic [CFG_W-1:0]                 cfg_data;

    rms_current_meter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    rms_window_tracker meter_model = new();

    bit          tx_steady;
    bit          rx_steady;
    int unsigned samples_sent;
    int unsigned cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, a few long ones, none at all in steady stretches
    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    function automatic logic [SMP_W-1:0] make_sample(int mode, int level, int swing);
        int v;
        if (mode == 0)
            return SMP_W'($urandom_range(0, (1 << SMP_W) - 1));
        v = level + $urandom_range(0, 2 * swing) - swing;
        if (v < 0)
            v = 0;
        if (v > (1 << SMP_W) - 1)
            v = (1 << SMP_W) - 1;
        return v[SMP_W-1:0];
    endfunction

    // all tasks start and end at a falling edge
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we   = 1'b1;
        cfg_addr = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we   = 1'b0;
        meter_model.write_reg(idx, value);
    endtask

    task automatic send_sample(logic [SMP_W-1:0] raw);
        int gap;
        gap = pick_gap(tx_steady);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {{(rcm_pkg::IN_DATA_W - SMP_W){1'b0}}, raw};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        meter_model.note_sample(raw);
        samples_sent++;
        @(negedge clk);
    endtask

    // stop the request stream and let the block finish every window in flight
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (meter_model.expected_rms.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_list(logic [SMP_W-1:0] vals[$]);
        foreach (vals[i])
            send_sample(vals[i]);
        wait_idle();
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            stall = pick_gap(rx_steady);
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            meter_model.check_result(m_axis_tdata);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned target;
        int          mode, level, swing, win, n, r;
        logic [CFG_W-1:0] cal;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_addr      = rcm_pkg::REG_CALIBRATION;
        cfg_data      = '0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        samples_sent  = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // one-sample windows at full calibration, field extremes
        write_reg(rcm_pkg::REG_CALIBRATION, CAL_MAX);
        write_reg(rcm_pkg::REG_SAMPLE_COUNT, CFG_W'(1));
        send_list('{12'd4095, 12'd0, 12'd4095, 12'd0, 12'd2048, 12'd2047, 12'd1, 12'd4094});

        // zero window size behaves as one
        write_reg(rcm_pkg::REG_SAMPLE_COUNT, CFG_W'(0));
        send_list('{12'd0, 12'd4095, 12'd3000});

        // window lowered below the fill level closes at the next sample
        write_reg(rcm_pkg::REG_SAMPLE_COUNT, CFG_W'(5));
        send_list('{12'd4095, 12'd4095, 12'd0});
        write_reg(rcm_pkg::REG_SAMPLE_COUNT, CFG_W'(2));
        send_list('{12'd100});

        // zero calibration, then the smallest nonzero one
        write_reg(rcm_pkg::REG_CALIBRATION, CFG_W'(0));
        write_reg(rcm_pkg::REG_SAMPLE_COUNT, CFG_W'(3));
        send_list('{12'd4095, 12'd0, 12'd4095});
        write_reg(rcm_pkg::REG_CALIBRATION, CFG_W'(1));
        write_reg(rcm_pkg::REG_SAMPLE_COUNT, CFG_W'(2));
        send_list('{12'd0, 12'd4095});

        target = samples_sent + RANDOM_ITEMS;
        while (samples_sent < target)
        begin
            r = $urandom_range(0, 9);
            if (r < 2)
                cal = $urandom_range(0, 1) ? CAL_MAX : '0;
            else if (r < 8)
                cal = CFG_W'($urandom_range(0, CAL_MAX));
            if (r < 8)
                write_reg(rcm_pkg::REG_CALIBRATION, cal);
            r = $urandom_range(0, 99);
            if (r < 10)
                win = $urandom_range(0, 1);
            else if (r < 85)
                win = $urandom_range(2, 24);
            else
                win = $urandom_range(25, 300);
            if ($urandom_range(0, 3) != 0)
                write_reg(rcm_pkg::REG_SAMPLE_COUNT, CFG_W'(win));
            else
                win = int'(meter_model.window_len);
            if (win == 0)
                win = 1;
            // whole windows most of the time, a partial one left over now and then
            n = win * $urandom_range(1, 4);
            if ($urandom_range(0, 2) == 0)
                n = n + $urandom_range(1, 5);
            if (n > 400)
                n = 400;
            mode  = $urandom_range(0, 1);
            level = $urandom_range(0, 1) ? $urandom_range(0, 4095)
                                         : ($urandom_range(0, 1) ? 4095 : 0);
            swing = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(200, 2047);
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            repeat (n)
                send_sample(make_sample(mode, level, swing));
            wait_idle();
        end

        // long window at full calibration with a strong dc bias
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        write_reg(rcm_pkg::REG_CALIBRATION, CAL_MAX);
        write_reg(rcm_pkg::REG_SAMPLE_COUNT, CFG_W'(LONG_WINDOW));
        repeat (LONG_WINDOW)
            send_sample(make_sample(1, 3800, 295));
        wait_idle();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (meter_model.errors == 0 && meter_model.expected_rms.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
